FILE: hdl/mpiu_pkg.sv
// ----------------------------------------------------------------------------
// Mutex priority inheritance unit package
// Sizes, request and status codes, payload types and sequencer states.
// ----------------------------------------------------------------------------
package mpiu_pkg;

  localparam int NUM_TASKS   = 16;
  localparam int NUM_MUTEXES = 8;
  localparam int WAIT_DEPTH  = 8;

  localparam int TaskW    = $clog2(NUM_TASKS);
  localparam int MutW     = $clog2(NUM_MUTEXES);
  localparam int DepW     = $clog2(WAIT_DEPTH);
  localparam int CntW     = $clog2(WAIT_DEPTH + 1);
  localparam int StepW    = $clog2(NUM_TASKS + 1);
  localparam int PrioW    = 8;
  localparam int MemAw    = MutW + DepW;
  localparam int MemDepth = NUM_MUTEXES * WAIT_DEPTH;

  localparam logic [1:0] REQ_SET    = 2'd0;
  localparam logic [1:0] REQ_LOCK   = 2'd1;
  localparam logic [1:0] REQ_UNLOCK = 2'd2;
  localparam logic [1:0] REQ_NOP    = 2'd3;

  localparam logic [2:0] STS_ACQUIRED  = 3'd0;
  localparam logic [2:0] STS_BLOCKED   = 3'd1;
  localparam logic [2:0] STS_FULL      = 3'd2;
  localparam logic [2:0] STS_FREED     = 3'd3;
  localparam logic [2:0] STS_HANDED    = 3'd4;
  localparam logic [2:0] STS_NOT_OWNER = 3'd5;
  localparam logic [2:0] STS_PRIO_SET  = 3'd6;

  typedef struct packed {
    logic [1:0] req_type;
    logic [2:0] mutex_id;
    logic [3:0] task_id;
    logic [7:0] base_priority;
  } in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] woken_task;
    logic [7:0] owner_priority;
  } out_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_LK_OWN, S_BST_T, S_BST_M, S_LK_WAIT,
    S_INS_RD, S_INS_CMP, S_SHF_RD, S_SHF_WR, S_INS_WR,
    S_RS_MUT, S_RS_RD, S_RS_CMP, S_RS_WR,
    S_POP, S_POP_HD, S_POP_SH, S_POP_WR, S_POP_FIN,
    S_FIN_OWN, S_FIN_T, S_RESULT
  } st_e;

endpackage

FILE: hdl/mutex_priority_inheritance_unit.sv
// ----------------------------------------------------------------------------
// Mutex priority inheritance unit
// Lock, unlock and base priority requests with priority inheritance.
// ----------------------------------------------------------------------------
// Usage: requests arrive on the in channel (valid/ready); each produces exactly
// one result on the out channel (valid/ready). The single bit configuration
// register (inheritance enable, reset 1) is written on the cfg channel, which
// is always ready.
// A request is worked on by a sequencer around one magnitude comparator, one
// read/write port into the task tables, one into the mutex tables and the
// wait queue memory (one read, one write, registered read). One request is
// in flight at a time; in_ready is high only while the sequencer is idle.
// A set request, an unknown request and a lock or unlock of a free mutex go
// straight from decode to the result; a refused lock or an unlock by a
// non-owner reads the owner's priority before the result. A blocking lock walks
// the boost chain, scans the queue for its place, moves the entries behind it
// and writes itself in. An unlock by the owner may first restore its priority
// from the waiters on its other held mutexes, then frees the mutex or hands it
// to the queue head and moves the further waiters up.
// A new request can be accepted in the cycle after the result is registered.
// Reset clears all task and mutex state at once; the queue memory needs no
// clearing as entries beyond a queue's count are never used.
// A finished result waits in the output register; while it is not taken the
// next request can be accepted but its result holds in the last state.
module mutex_priority_inheritance_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  mpiu_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output mpiu_pkg::out_t out_data_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic           cfg_data_i
);
  import mpiu_pkg::*;

  st_e state_q, state_d;
  logic inh_en_q;

  // Task tables.
  logic [PrioW-1:0] eff_q  [NUM_TASKS];
  logic [PrioW-1:0] base_q [NUM_TASKS];
  logic             inh_q  [NUM_TASKS];
  logic             wait_q [NUM_TASKS];
  logic [MutW-1:0]  won_q  [NUM_TASKS];
  // Mutex tables.
  logic             held_q  [NUM_MUTEXES];
  logic [TaskW-1:0] owner_q [NUM_MUTEXES];
  logic [CntW-1:0]  cnt_tq  [NUM_MUTEXES];
  // Wait queues.
  logic [TaskW-1:0] wq_mem [MemDepth];
  logic [TaskW-1:0] rdata_q;

  // Request and working registers.
  logic [1:0]       req_q;
  logic [MutW-1:0]  m_q, wm_q, rs_m_q;
  logic [TaskW-1:0] t_q, own_q, ct_q, woken_q;
  logic [PrioW-1:0] bp_q, pt_q, oprio_q;
  logic [CntW-1:0]  cnt_q, cnt2_q, i_q, pos_q;
  logic [StepW-1:0] step_q;
  logic [MutW:0]    sm_q;
  logic [2:0]       status_q;
  logic             out_valid_q;
  out_t             out_q;

  // Port controls.
  logic [TaskW-1:0] ta;
  logic [MutW-1:0]  ma;
  logic [MemAw-1:0] ra, wa;
  logic [TaskW-1:0] wd;
  logic             mem_we;
  logic             we_eff, we_base, we_inh, we_wait, we_won;
  logic [PrioW-1:0] wd_eff;
  logic             wd_inh, wd_wait;
  logic [MutW-1:0]  wd_won;
  logic             we_held, we_owner, we_cnt;
  logic             wd_held;
  logic [TaskW-1:0] wd_owner;
  logic [CntW-1:0]  wd_cnt;
  logic [PrioW-1:0] cmp_a, cmp_b;
  logic             lt;

  logic [PrioW-1:0] eff_rd, base_rd;
  logic             inh_rd, wait_rd, held_rd;
  logic [MutW-1:0]  won_rd;
  logic [TaskW-1:0] owner_rd;
  logic [CntW-1:0]  cnt_rd, i_inc, i_dec;
  logic             owned, rs_match;

  assign eff_rd   = eff_q[ta];
  assign base_rd  = base_q[ta];
  assign inh_rd   = inh_q[ta];
  assign wait_rd  = wait_q[ta];
  assign won_rd   = won_q[ta];
  assign held_rd  = held_q[ma];
  assign owner_rd = owner_q[ma];
  assign cnt_rd   = cnt_tq[ma];
  assign i_inc    = i_q + CntW'(1);
  assign i_dec    = i_q - CntW'(1);
  assign lt       = cmp_a < cmp_b;
  assign owned    = held_rd && (owner_rd == t_q);
  assign rs_match = (sm_q[MutW-1:0] != m_q) && owned;

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_DECODE;
      S_DECODE: begin
        case (req_q)
          REQ_LOCK: begin
            if (!held_rd) state_d = S_RESULT;
            else if (cnt_rd >= CntW'(WAIT_DEPTH)) state_d = S_FIN_OWN;
            else state_d = S_LK_OWN;
          end
          REQ_UNLOCK: begin
            if (!held_rd) state_d = S_RESULT;
            else if (owner_rd != t_q) state_d = S_FIN_OWN;
            else if (inh_en_q && inh_rd) state_d = S_RS_MUT;
            else state_d = S_POP;
          end
          default: state_d = S_RESULT;
        endcase
      end
      S_LK_OWN: state_d = (inh_en_q && lt) ? S_BST_T : S_LK_WAIT;
      S_BST_T: state_d = (lt && wait_rd) ? S_BST_M : S_LK_WAIT;
      S_BST_M: begin
        if (!held_rd || (step_q + StepW'(1) == StepW'(NUM_TASKS))) state_d = S_LK_WAIT;
        else state_d = S_BST_T;
      end
      S_LK_WAIT: state_d = S_INS_RD;
      S_INS_RD: state_d = (i_q == cnt_q) ? S_SHF_RD : S_INS_CMP;
      S_INS_CMP: state_d = lt ? S_SHF_RD : S_INS_RD;
      S_SHF_RD: state_d = (i_q == pos_q) ? S_INS_WR : S_SHF_WR;
      S_SHF_WR: state_d = S_SHF_RD;
      S_INS_WR: state_d = S_FIN_OWN;
      S_RS_MUT: begin
        if (sm_q == (MutW+1)'(NUM_MUTEXES)) state_d = S_RS_WR;
        else if (rs_match) state_d = S_RS_RD;
      end
      S_RS_RD: state_d = (i_q == cnt2_q) ? S_RS_MUT : S_RS_CMP;
      S_RS_CMP: state_d = S_RS_RD;
      S_RS_WR: state_d = S_POP;
      S_POP: state_d = (cnt_q == '0) ? S_FIN_T : S_POP_HD;
      S_POP_HD: state_d = S_POP_SH;
      S_POP_SH: state_d = (i_inc >= cnt_q) ? S_POP_FIN : S_POP_WR;
      S_POP_WR: state_d = S_POP_SH;
      S_POP_FIN: state_d = S_FIN_T;
      S_FIN_OWN: state_d = S_RESULT;
      S_FIN_T: state_d = S_RESULT;
      S_RESULT: if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Port addresses, write enables and comparator operands.
  always_comb begin
    ta = t_q;  ma = m_q;
    ra = {m_q, i_q[DepW-1:0]};
    wa = {m_q, i_q[DepW-1:0]};
    wd = rdata_q;  mem_we = 1'b0;
    we_eff = 1'b0; we_base = 1'b0; we_inh = 1'b0; we_wait = 1'b0; we_won = 1'b0;
    wd_eff = pt_q; wd_inh = 1'b0; wd_wait = 1'b0; wd_won = '0;
    we_held = 1'b0; we_owner = 1'b0; we_cnt = 1'b0;
    wd_held = 1'b0; wd_owner = '0; wd_cnt = cnt_q;
    cmp_a = pt_q; cmp_b = eff_rd;
    case (state_q)
      S_DECODE: begin
        cmp_a = bp_q;
        if (req_q == REQ_SET) begin
          we_base = 1'b1;
          we_eff  = 1'b1;
          we_inh  = 1'b1;
          wd_eff  = (!inh_rd || lt) ? bp_q : eff_rd;
          wd_inh  = inh_rd && !lt;
        end else if (req_q == REQ_LOCK && !held_rd) begin
          we_held  = 1'b1;
          wd_held  = 1'b1;
          we_owner = 1'b1;
          wd_owner = t_q;
        end
      end
      S_LK_OWN: ta = own_q;
      S_BST_T: begin
        ta = ct_q;
        if (lt) begin
          we_eff = 1'b1;
          we_inh = 1'b1;
          wd_inh = 1'b1;
        end
      end
      S_BST_M: ma = wm_q;
      S_LK_WAIT: begin
        we_wait = 1'b1;
        wd_wait = 1'b1;
        we_won  = 1'b1;
        wd_won  = m_q;
      end
      S_INS_CMP: ta = rdata_q;
      S_SHF_RD: ra = {m_q, i_dec[DepW-1:0]};
      S_SHF_WR: mem_we = 1'b1;
      S_INS_WR: begin
        mem_we = 1'b1;
        wa     = {m_q, pos_q[DepW-1:0]};
        wd     = t_q;
        we_cnt = 1'b1;
        wd_cnt = cnt_q + CntW'(1);
      end
      S_FIN_OWN: ta = own_q;
      S_RS_MUT: ma = sm_q[MutW-1:0];
      S_RS_RD: ra = {rs_m_q, i_q[DepW-1:0]};
      S_RS_CMP: begin
        ta    = rdata_q;
        cmp_a = eff_rd;
        cmp_b = pt_q;
      end
      S_RS_WR: begin
        we_eff = 1'b1;
        if (pt_q == base_rd) we_inh = 1'b1;
      end
      S_POP: begin
        ra = {m_q, {DepW{1'b0}}};
        if (cnt_q == '0) begin
          we_held  = 1'b1;
          we_owner = 1'b1;
        end
      end
      S_POP_SH: ra = {m_q, i_inc[DepW-1:0]};
      S_POP_WR: mem_we = 1'b1;
      S_POP_FIN: begin
        ta       = woken_q;
        we_owner = 1'b1;
        wd_owner = woken_q;
        we_cnt   = 1'b1;
        wd_cnt   = cnt_q - CntW'(1);
        we_wait  = 1'b1;
        we_won   = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      inh_en_q    <= 1'b1;
      out_valid_q <= 1'b0;
      for (int k = 0; k < NUM_TASKS; k++) begin
        eff_q[k]  <= '0;
        base_q[k] <= '0;
        inh_q[k]  <= 1'b0;
        wait_q[k] <= 1'b0;
        won_q[k]  <= '0;
      end
      for (int k = 0; k < NUM_MUTEXES; k++) begin
        held_q[k]  <= 1'b0;
        owner_q[k] <= '0;
        cnt_tq[k]  <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) inh_en_q <= cfg_data_i;
      if (state_q == S_RESULT && (!out_valid_q || out_ready_i)) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (we_eff)   eff_q[ta]   <= wd_eff;
      if (we_base)  base_q[ta]  <= bp_q;
      if (we_inh)   inh_q[ta]   <= wd_inh;
      if (we_wait)  wait_q[ta]  <= wd_wait;
      if (we_won)   won_q[ta]   <= wd_won;
      if (we_held)  held_q[ma]  <= wd_held;
      if (we_owner) owner_q[ma] <= wd_owner;
      if (we_cnt)   cnt_tq[ma]  <= wd_cnt;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) wq_mem[wa] <= wd;
    rdata_q <= wq_mem[ra];
  end

  // Working registers of the sequencer.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        req_q <= in_data_i.req_type;
        m_q   <= in_data_i.mutex_id;
        t_q   <= in_data_i.task_id;
        bp_q  <= in_data_i.base_priority;
      end
      S_DECODE: begin
        // An owner's unlock starts its restore search from the base priority.
        pt_q    <= (req_q == REQ_UNLOCK && owned) ? base_rd : eff_rd;
        own_q   <= owner_rd;
        cnt_q   <= cnt_rd;
        woken_q <= '0;
        sm_q    <= '0;
        case (req_q)
          REQ_SET: begin
            status_q <= STS_PRIO_SET;
            oprio_q  <= wd_eff;
          end
          REQ_LOCK: begin
            oprio_q <= eff_rd;
            if (!held_rd) status_q <= STS_ACQUIRED;
            else if (cnt_rd >= CntW'(WAIT_DEPTH)) status_q <= STS_FULL;
            else status_q <= STS_BLOCKED;
          end
          REQ_UNLOCK: begin
            status_q <= STS_NOT_OWNER;
            oprio_q  <= '0;
          end
          default: begin
            status_q <= STS_PRIO_SET;
            oprio_q  <= '0;
          end
        endcase
      end
      S_LK_OWN: begin
        ct_q   <= own_q;
        step_q <= '0;
      end
      S_BST_T: wm_q <= won_rd;
      S_BST_M: begin
        ct_q   <= owner_rd;
        step_q <= step_q + StepW'(1);
      end
      S_LK_WAIT: begin
        pt_q <= eff_rd;
        i_q  <= '0;
      end
      S_INS_RD: begin
        if (i_q == cnt_q) begin
          pos_q <= cnt_q;
          i_q   <= cnt_q;
        end
      end
      S_INS_CMP: begin
        if (lt) begin
          pos_q <= i_q;
          i_q   <= cnt_q;
        end else begin
          i_q <= i_inc;
        end
      end
      S_SHF_WR: i_q <= i_dec;
      S_RS_MUT: begin
        if (sm_q != (MutW+1)'(NUM_MUTEXES)) begin
          sm_q   <= sm_q + (MutW+1)'(1);
          rs_m_q <= sm_q[MutW-1:0];
          cnt2_q <= cnt_rd;
          i_q    <= '0;
        end
      end
      S_RS_CMP: begin
        if (lt) pt_q <= eff_rd;
        i_q <= i_inc;
      end
      S_POP: begin
        i_q <= '0;
        if (cnt_q == '0) status_q <= STS_FREED;
      end
      S_POP_HD: woken_q <= rdata_q;
      S_POP_WR: i_q <= i_inc;
      S_POP_FIN: status_q <= STS_HANDED;
      S_FIN_OWN: oprio_q <= eff_rd;
      S_FIN_T: oprio_q <= eff_rd;
      S_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          out_q.status         <= status_q;
          out_q.woken_task     <= woken_q;
          out_q.owner_priority <= oprio_q;
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: hdl/mpiu_checker.sv
// ----------------------------------------------------------------------------
// Mutex priority inheritance unit port checker
// Checks handshake and result rules seen at the top level ports.
// ----------------------------------------------------------------------------
module mpiu_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input mpiu_pkg::out_t out_data_o
);
  import mpiu_pkg::*;

  // A result not yet taken stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result withdrawn before its transaction completed");

  // Only one request is worked on at a time.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while another is in progress");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.status <= STS_PRIO_SET)
    else $error("undefined status code");

  // A woken task is reported only on a hand-off.
  a_woken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != STS_HANDED |-> out_data_o.woken_task == '0)
    else $error("woken task reported without a hand-off");

endmodule

bind mutex_priority_inheritance_unit mpiu_checker u_mpiu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// Mutex priority inheritance unit testbench
// Drives lock, unlock and priority requests with random idling on both sides,
// predicts every result with a behavioural model and checks each transaction.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mpiu_pkg::*;

  class mutex_scoreboard;
    bit       inherit_on;
    bit [7:0] eff_prio [NUM_TASKS];
    bit [7:0] base_prio [NUM_TASKS];
    bit       boosted [NUM_TASKS];
    bit       waiting [NUM_TASKS];
    bit [2:0] wait_mutex [NUM_TASKS];
    bit       held [NUM_MUTEXES];
    bit [3:0] owner [NUM_MUTEXES];
    bit [3:0] waiters [NUM_MUTEXES][$];
    out_t     pending [$];
    int       mismatches;

    function new();
      inherit_on = 1'b1;
      mismatches = 0;
      foreach (eff_prio[i]) begin
        eff_prio[i] = '0; base_prio[i] = '0; boosted[i] = 0;
        waiting[i] = 0; wait_mutex[i] = '0;
      end
      foreach (held[i]) begin
        held[i] = 0; owner[i] = '0;
      end
    endfunction

    function void boost_owners(bit [3:0] t, bit [7:0] p);
      for (int s = 0; s < NUM_TASKS; s++) begin
        if (p >= eff_prio[t]) return;
        boosted[t] = 1; eff_prio[t] = p;
        if (!waiting[t]) return;
        if (!held[wait_mutex[t]]) return;
        t = owner[wait_mutex[t]];
      end
    endfunction

    function void enqueue_waiter(bit [2:0] m, bit [3:0] t);
      int pos;
      pos = waiters[m].size();
      for (int i = 0; i < waiters[m].size(); i++)
        if (eff_prio[t] < eff_prio[waiters[m][i]]) begin
          pos = i;
          break;
        end
      waiters[m].insert(pos, t);
    endfunction

    function void drop_boost(bit [3:0] t, bit [2:0] rel);
      bit [7:0] need;
      need = base_prio[t];
      if (!boosted[t]) return;
      for (int m = 0; m < NUM_MUTEXES; m++) begin
        if (m == rel || !held[m] || owner[m] != t) continue;
        foreach (waiters[m][w])
          if (eff_prio[waiters[m][w]] < need) need = eff_prio[waiters[m][w]];
      end
      eff_prio[t] = need;
      if (need == base_prio[t]) boosted[t] = 0;
    endfunction

    function void note_request(in_t r);
      out_t     e;
      bit [2:0] m;
      bit [3:0] t, o, w;
      m = r.mutex_id; t = r.task_id;
      e = '{status: STS_PRIO_SET, woken_task: '0, owner_priority: '0};
      case (r.req_type)
        REQ_SET: begin
          base_prio[t] = r.base_priority;
          if (!boosted[t]) eff_prio[t] = r.base_priority;
          else if (r.base_priority < eff_prio[t]) begin
            eff_prio[t] = r.base_priority; boosted[t] = 0;
          end
          e.owner_priority = eff_prio[t];
        end
        REQ_LOCK: begin
          if (!held[m]) begin
            held[m] = 1; owner[m] = t;
            e.status = STS_ACQUIRED; e.owner_priority = eff_prio[t];
          end else begin
            o = owner[m];
            if (waiters[m].size() >= WAIT_DEPTH) e.status = STS_FULL;
            else begin
              if (inherit_on && eff_prio[t] < eff_prio[o]) boost_owners(o, eff_prio[t]);
              waiting[t] = 1; wait_mutex[t] = m;
              enqueue_waiter(m, t);
              e.status = STS_BLOCKED;
            end
            e.owner_priority = eff_prio[o];
          end
        end
        REQ_UNLOCK: begin
          if (!held[m] || owner[m] != t) begin
            e.status = STS_NOT_OWNER;
            if (held[m]) e.owner_priority = eff_prio[owner[m]];
          end else begin
            if (inherit_on) drop_boost(t, m);
            if (waiters[m].size() > 0) begin
              w = waiters[m].pop_front();
              waiting[w] = 0; wait_mutex[w] = '0; owner[m] = w;
              e.status = STS_HANDED; e.woken_task = w;
            end else begin
              held[m] = 0; owner[m] = '0; e.status = STS_FREED;
            end
            e.owner_priority = eff_prio[t];
          end
        end
        default: ;
      endcase
      pending.push_back(e);
    endfunction

    function void check_result(out_t got);
      out_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      e = pending.pop_front();
      if (got.status !== e.status || got.woken_task !== e.woken_task ||
          got.owner_priority !== e.owner_priority) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p, got %p", e, got);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0, in_ready_o;
  in_t  in_data_i = '0;
  logic out_valid_o, out_ready_i = 1'b0;
  out_t out_data_o;
  logic cfg_valid_i = 1'b0, cfg_ready_o, cfg_data_i = 1'b0;

  mutex_scoreboard sb = new();
  bit quiet_tail = 0;
  bit long_stall = 0;
  bit hot_tasks  = 0;

  mutex_priority_inheritance_unit dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Result side: random bursts of back-pressure, plus one long hold-off.
  initial begin
    int gap;
    forever begin
      @(negedge clk_i);
      if (long_stall) begin
        out_ready_i <= 1'b0;
        repeat (300) @(negedge clk_i);
        long_stall = 0;
      end
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 5);
        out_ready_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end else out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i)
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_data_o);

  // Valid is left high after an acceptance; the block is busy then, so the
  // next call either replaces the payload or drops valid for an idle burst.
  task automatic send_request(in_t r);
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    in_data_i  <= r;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(r);
    @(negedge clk_i);
  endtask

  task automatic write_inherit(bit v);
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    cfg_data_i  <= v;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.inherit_on = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic in_t random_request();
    in_t r;
    int k;
    k = $urandom_range(0, 99);
    r.req_type = (k < 15) ? REQ_SET : (k < 58) ? REQ_LOCK : (k < 97) ? REQ_UNLOCK : REQ_NOP;
    r.mutex_id = hot_tasks ? 3'($urandom_range(0, 1)) : 3'($urandom_range(0, 7));
    r.task_id  = hot_tasks ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 5));
    k = $urandom_range(0, 9);
    r.base_priority = (k == 0) ? 8'd0 : (k == 1) ? 8'd255 : 8'($urandom_range(0, 255));
    return r;
  endfunction

  function automatic in_t mk(logic [1:0] q, int m, int t, int p);
    in_t r;
    r.req_type = q; r.mutex_id = 3'(m); r.task_id = 4'(t); r.base_priority = 8'(p);
    return r;
  endfunction

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // Directed: priorities, a boost chain, a full queue and odd unlocks.
    send_request(mk(REQ_SET, 0, 0, 200));
    send_request(mk(REQ_SET, 7, 1, 100));
    send_request(mk(REQ_SET, 0, 15, 0));
    send_request(mk(REQ_SET, 0, 2, 255));
    send_request(mk(REQ_LOCK, 0, 0, 0));
    send_request(mk(REQ_LOCK, 1, 1, 0));
    send_request(mk(REQ_LOCK, 0, 1, 0));
    send_request(mk(REQ_LOCK, 1, 15, 0));
    send_request(mk(REQ_SET, 0, 0, 50));
    send_request(mk(REQ_UNLOCK, 1, 2, 0));
    send_request(mk(REQ_UNLOCK, 5, 2, 0));
    send_request(mk(REQ_NOP, 7, 15, 255));
    for (int i = 2; i < 12; i++) send_request(mk(REQ_LOCK, 7, i, 0));
    send_request(mk(REQ_UNLOCK, 1, 1, 0));
    send_request(mk(REQ_UNLOCK, 0, 0, 0));
    send_request(mk(REQ_LOCK, 0, 0, 0));
    write_inherit(1'b0);
    for (int i = 0; i < 400; i++) send_request(random_request());
    write_inherit(1'b1);
    hot_tasks = 1;
    long_stall = 1;
    for (int i = 0; i < 600; i++) send_request(random_request());
    write_inherit(1'b0);
    hot_tasks = 0;
    for (int i = 0; i < 250; i++) send_request(random_request());
    write_inherit(1'b1);
    quiet_tail = 1;
    for (int i = 0; i < 370; i++) send_request(random_request());
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    if (sb.mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #6000000;
    $display("status: fail");
    $finish;
  end
endmodule

FILE: mutex_priority_inheritance_unit.f
hdl/mpiu_pkg.sv
hdl/mutex_priority_inheritance_unit.sv
hdl/mpiu_checker.sv
tb/tb_top.sv
